### sv/bqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_pkg: shared types and codes of the burst queue dispatcher
// Holds the scan record handed along the queue cells, the write command
// broadcast to the cells, and the mode, outcome and register codes.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int QIDX_W = 3;           // queue index width (up to eight queues)
  localparam int CNT_W  = QIDX_W + 1;  // queue count width
  localparam int TIME_W = 32;

  // Configuration register indexes.
  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  typedef enum logic [1:0] {
    MODE_DYNAMIC = 2'd0,
    MODE_NO_PREEMPT = 2'd1,
    MODE_ROUND_ROBIN = 2'd2,
    MODE_STATIC = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OUT_NO_RULE = 3'd0,
    OUT_BUSY_MATCH = 3'd1,
    OUT_IDLE_REUSE = 3'd2,
    OUT_FRESH = 3'd3,
    OUT_PREEMPT = 3'd4,
    OUT_DROPPED = 3'd5
  } outcome_t;

  // Running result of one scan, passed from cell to cell.
  typedef struct packed {
    logic              vld;
    logic              busy_f;
    logic [QIDX_W-1:0] busy_i;
    logic              idle_f;
    logic [QIDX_W-1:0] idle_i;
    logic              free_f;
    logic [QIDX_W-1:0] free_i;
    logic              best_f;
    logic [QIDX_W-1:0] best_i;
    logic [TIME_W-1:0] best_t;
    logic              tgt_same;
    logic              tgt_idle;
  } rec_t;

  // Update of one queue entry after a decision.
  typedef struct packed {
    logic              en;
    logic [QIDX_W-1:0] sel;
    logic              set_label;
    logic [TIME_W-1:0] stamp;
  } wr_t;

endpackage

### sv/bqd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_cell: one queue entry of the dispatcher
// Keeps the label and last-access time of one queue, folds them into the
// scan record that passes through, and registers the record for the next cell.
// ----------------------------------------------------------------------------
module bqd_cell
  import bqd_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int LABEL_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CNT_W-1:0]      n_q,
  input  logic [LABEL_BITS-1:0] qlabel,
  input  logic                  idle_bit,
  input  logic [QIDX_W-1:0]     tgt,
  input  rec_t                  rec_in,
  output rec_t                  rec_out,
  input  wr_t                   wr,
  input  logic [LABEL_BITS-1:0] wr_label
);

  localparam logic [QIDX_W-1:0] MY_IDX = QIDX_W'(IDX);

  logic [LABEL_BITS-1:0] label_r;
  logic [TIME_W-1:0]     time_r;
  rec_t                  rec_r;
  rec_t                  rec_nxt;
  logic                  active;
  logic                  same;

  assign active = {1'b0, MY_IDX} < n_q;
  assign same   = label_r == qlabel;

  always_comb begin
    rec_nxt = rec_in;
    if (active) begin
      if (!idle_bit && same && !rec_in.busy_f) begin
        rec_nxt.busy_f = 1'b1;
        rec_nxt.busy_i = MY_IDX;
      end
      if (idle_bit && same && !rec_in.idle_f) begin
        rec_nxt.idle_f = 1'b1;
        rec_nxt.idle_i = MY_IDX;
      end
      if (idle_bit && !rec_in.free_f) begin
        rec_nxt.free_f = 1'b1;
        rec_nxt.free_i = MY_IDX;
      end
      // Strictly older wins, so ties stay with the lower index.
      if (!rec_in.best_f || (time_r < rec_in.best_t)) begin
        rec_nxt.best_f = 1'b1;
        rec_nxt.best_i = MY_IDX;
        rec_nxt.best_t = time_r;
      end
    end
    if (tgt == MY_IDX) begin
      rec_nxt.tgt_same = same;
      rec_nxt.tgt_idle = idle_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.vld <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= '0;
      time_r  <= '0;
    end else if (wr.en && (wr.sel == MY_IDX)) begin
      if (wr.set_label) begin
        label_r <= wr_label;
      end
      time_r <= wr.stamp;
    end
  end

  assign rec_out = rec_r;

endmodule

### sv/burst_queue_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_queue_dispatcher: burst-assembly queue selection per packet
// Picks a queue for each packet word from its label, the idle mask and the
// time, over a row of queue cells that each hold one queue's label and age.
// ----------------------------------------------------------------------------
// The dispatcher handles one packet word at a time and returns exactly one
// result word for it. From acceptance to the result register, a packet passes
// through a bit-serial remainder unit that forms the static queue
// (label - 1) mod n, a launch step that starts the scan, the scan record
// walking the row of queue cells one cell per cycle, and a decide step that
// updates the chosen cell. The next word is accepted once the block is back
// in its idle state, in the cycle after the result is registered, so the
// block takes no new word while one is in flight; a finished result may still
// be waiting in the output register at that time, and a result that cannot
// leave the output register holds the block in its decide step until the
// receiver takes the previous one. The user must write configuration only
// while no packet is in flight; the block itself does not enforce this.
// Queue labels, access times and the round-robin pointer all reset to zero.
module burst_queue_dispatcher
  import bqd_pkg::*;
#(
  parameter int NUM_QUEUES = 8,
  parameter int LABEL_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // Packet words in.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // target_label[9:0], idle_mask[17:10],
                                  // now_time[49:18], zero fill above
  input  logic        in_tuser,   // rule_matched
  // Decision words out.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // dispatched[0], queue_index[3:1],
                                  // flush_request[4], label_assigned[5],
                                  // outcome[8:6], zero fill above
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int BIT_W = (LABEL_BITS > 1) ? $clog2(LABEL_BITS) : 1;
  localparam logic [CNT_W-1:0] NQ = CNT_W'(NUM_QUEUES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_LAUNCH,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [1:0]            mode_r;
  logic [CNT_W-1:0]      active_r;
  logic [QIDX_W-1:0]     rr_r;
  logic                  matched_r;
  logic [LABEL_BITS-1:0] label_r;
  logic [LABEL_BITS-1:0] dvd_r;
  logic [7:0]            idle_r;
  logic [TIME_W-1:0]     now_r;
  logic [BIT_W-1:0]      bit_r;
  logic [QIDX_W-1:0]     rem_r;
  logic [QIDX_W-1:0]     tgt_r;
  rec_t                  res_r;
  logic                  out_tvalid_r;
  logic [15:0]           out_tdata_r;

  logic [CNT_W-1:0]      n_q;
  logic [LABEL_BITS+9:0] label_ext;
  logic [LABEL_BITS-1:0] label_in;
  logic [CNT_W-1:0]      rem_try;
  logic [QIDX_W-1:0]     rem_nxt;
  logic [QIDX_W-1:0]     rr_mod;
  rec_t                  rec_w [NUM_QUEUES+1];
  wr_t                   wr;
  logic                  fire;

  // Decision outputs.
  logic                  go;
  logic [QIDX_W-1:0]     sel;
  logic                  flush;
  logic                  assign_lbl;
  outcome_t              outcome;
  logic [QIDX_W-1:0]     rr_nxt;
  logic                  rr_upd;

  // Queue count clamped to 1..NUM_QUEUES.
  always_comb begin
    if (active_r == '0) begin
      n_q = CNT_W'(1);
    end else if (active_r > NQ) begin
      n_q = NQ;
    end else begin
      n_q = active_r;
    end
  end

  assign label_ext = {{LABEL_BITS{1'b0}}, in_tdata[9:0]};
  assign label_in  = label_ext[LABEL_BITS-1:0];

  // One restoring step of the remainder: shift in the next dividend bit.
  assign rem_try = {rem_r, dvd_r[bit_r]};
  assign rem_nxt = (rem_try >= n_q) ? QIDX_W'(rem_try - n_q) : QIDX_W'(rem_try);

  // The round-robin pointer is below eight, so a few subtractions bring it
  // into the active range after the queue count shrinks.
  function automatic logic [QIDX_W-1:0] wrap_idx(input logic [QIDX_W-1:0] v,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = {1'b0, v};
    for (int k = 0; k < (1 << QIDX_W) - 1; k++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r[QIDX_W-1:0];
  endfunction

  assign rr_mod = wrap_idx(rr_r, n_q);

  // The scan record enters the first cell fresh.
  always_comb begin
    rec_w[0]     = '0;
    rec_w[0].vld = state_r == S_LAUNCH;
  end

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_cell
    bqd_cell #(
      .IDX        (g),
      .LABEL_BITS (LABEL_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .n_q      (n_q),
      .qlabel   (label_r),
      .idle_bit (idle_r[g]),
      .tgt      (tgt_r),
      .rec_in   (rec_w[g]),
      .rec_out  (rec_w[g+1]),
      .wr       (wr),
      .wr_label (label_r)
    );
  end

  // Final decision from the completed scan record.
  always_comb begin
    go         = 1'b0;
    sel        = '0;
    flush      = 1'b0;
    assign_lbl = 1'b0;
    outcome    = OUT_NO_RULE;
    rr_upd     = 1'b0;
    rr_nxt     = ({1'b0, tgt_r} + CNT_W'(1) >= n_q) ? '0 : tgt_r + QIDX_W'(1);
    if (matched_r) begin
      unique case (mode_t'(mode_r))
        MODE_DYNAMIC, MODE_NO_PREEMPT: begin
          priority if (res_r.busy_f) begin
            go = 1'b1; sel = res_r.busy_i; outcome = OUT_BUSY_MATCH;
          end else if (res_r.idle_f) begin
            go = 1'b1; sel = res_r.idle_i; outcome = OUT_IDLE_REUSE;
          end else if (res_r.free_f) begin
            go = 1'b1; sel = res_r.free_i; outcome = OUT_FRESH; assign_lbl = 1'b1;
          end else if (mode_t'(mode_r) == MODE_DYNAMIC) begin
            go = 1'b1; sel = res_r.best_i; outcome = OUT_PREEMPT;
            flush = 1'b1; assign_lbl = 1'b1;
          end else begin
            outcome = OUT_DROPPED;
          end
        end
        MODE_ROUND_ROBIN: begin
          go     = 1'b1;
          sel    = tgt_r;
          rr_upd = 1'b1;
          if (res_r.tgt_same) begin
            outcome = res_r.tgt_idle ? OUT_IDLE_REUSE : OUT_BUSY_MATCH;
          end else begin
            outcome    = OUT_FRESH;
            assign_lbl = 1'b1;
            flush      = !res_r.tgt_idle;
          end
        end
        MODE_STATIC: begin
          priority if (res_r.tgt_same) begin
            go = 1'b1; sel = tgt_r;
            outcome = res_r.tgt_idle ? OUT_IDLE_REUSE : OUT_BUSY_MATCH;
          end else if (res_r.tgt_idle) begin
            go = 1'b1; sel = tgt_r; outcome = OUT_FRESH; assign_lbl = 1'b1;
          end else begin
            outcome = OUT_DROPPED;
          end
        end
        default: begin
          outcome = OUT_NO_RULE;
        end
      endcase
    end
  end

  // The result is only committed once the output register can take it.
  assign fire = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    wr.en        = fire && go;
    wr.sel       = sel;
    wr.set_label = assign_lbl;
    wr.stamp     = now_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_DYNAMIC;
      active_r <= NQ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[1:0];
        CFG_ACTIVE: active_r <= cfg_data;
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rr_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A new result replaces the one being taken in the same cycle.
      if (fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            matched_r <= in_tuser;
            label_r   <= label_in;
            dvd_r     <= label_in - LABEL_BITS'(1);
            idle_r    <= in_tdata[17:10];
            now_r     <= in_tdata[49:18];
            bit_r     <= BIT_W'(LABEL_BITS - 1);
            rem_r     <= '0;
            state_r   <= S_MOD;
          end
        end
        S_MOD: begin
          rem_r <= rem_nxt;
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            state_r <= S_LAUNCH;
            tgt_r   <= (mode_t'(mode_r) == MODE_ROUND_ROBIN) ? rr_mod : rem_nxt;
          end
        end
        S_LAUNCH: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (rec_w[NUM_QUEUES].vld) begin
            res_r   <= rec_w[NUM_QUEUES];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            out_tdata_r <= {7'd0, outcome, assign_lbl, flush, sel, go};
            if (rr_upd) begin
              rr_r <= rr_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
